>>> hw/rtl/gkrs_pkg.sv
// Shared types, constants and the exp2 table for the Gaussian kernel row-sum block.
package gkrs_pkg;

    localparam int DIST_W = 37;    // up to 31 squared Q8.8 differences
    localparam int SUM_W  = 27;    // up to 2047 terms of at most 1.0 in Q16.16
    localparam int FSUM_W = 48;    // sum after normalisation
    localparam int CNT_W  = 11;
    localparam int NA_W   = 5;
    localparam int DIV_W  = 48;

    localparam logic [31:0] LOG2E_Q16 = 32'd94548;
    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [53:0] T_CUTOFF  = 54'h00_0000_0018_0000;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // round(65536 * 2^(-k/32))
    localparam logic [16:0] EXP2_TAB [0:32] = '{
        17'd65536, 17'd64132, 17'd62757, 17'd61413, 17'd60097, 17'd58809, 17'd57549,
        17'd56316, 17'd55109, 17'd53928, 17'd52773, 17'd51642, 17'd50535, 17'd49452,
        17'd48393, 17'd47356, 17'd46341, 17'd45348, 17'd44376, 17'd43425, 17'd42495,
        17'd41584, 17'd40693, 17'd39821, 17'd38968, 17'd38133, 17'd37316, 17'd36516,
        17'd35734, 17'd34968, 17'd34219, 17'd33486, 17'd32768
    };

    typedef enum logic [2:0] {
        CFG_SAMPLE_COUNT = 3'd0,
        CFG_ATTRIB_COUNT = 3'd1,
        CFG_INV_TWO_SIG  = 3'd2,
        CFG_INV_NORM     = 3'd3,
        CFG_NORMED       = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic samp_we;
        logic flag_we;
        logic flag_wval;
    } st_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> hw/rtl/gkrs_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
module gkrs_mul
    import gkrs_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

>>> hw/rtl/gkrs_div.sv
// Restoring divider, one quotient bit per cycle.
module gkrs_div
    import gkrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_W-1:0]   dividend,
    input  logic [CNT_W-1:0]   divisor,
    output div_stat_t          stat,
    output logic [DIV_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = CNT_W'(shifted - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = CNT_W'(shifted);
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

>>> hw/rtl/gkrs_store.sv
// Sample attribute memory and missing-flag memory with clearing pass after reset.
module gkrs_store
    import gkrs_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_ATTRIB  = 16,
    localparam int SW = $clog2(MAX_SAMPLES),
    localparam int AD = $clog2(MAX_SAMPLES * MAX_ATTRIB)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  st_ctrl_t      ctrl,
    input  logic [AD-1:0] samp_addr,
    input  logic [15:0]   samp_wdata,
    output logic [15:0]   samp_rdata,
    input  logic [SW-1:0] flag_addr,
    output logic          flag_rdata,
    output logic          clear_busy
);

    logic [15:0] samp_mem [MAX_SAMPLES * MAX_ATTRIB];
    logic        flag_mem [MAX_SAMPLES];
    logic [15:0] samp_rd_reg;
    logic        flag_rd_reg;
    logic [SW:0] clr_reg;

    assign clear_busy = (clr_reg != (SW + 1)'(MAX_SAMPLES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clear_busy)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.samp_we)
        begin
            samp_mem[samp_addr] <= samp_wdata;
        end
        samp_rd_reg <= samp_mem[samp_addr];
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy)
        begin
            flag_mem[clr_reg[SW-1:0]] <= 1'b0;
        end
        else if (ctrl.flag_we)
        begin
            flag_mem[flag_addr] <= ctrl.flag_wval;
        end
        flag_rd_reg <= flag_mem[flag_addr];
    end

    assign samp_rdata = samp_rd_reg;
    assign flag_rdata = flag_rd_reg;

endmodule

>>> hw/rtl/gaussian_kernel_row_sum.sv
// Top level of the Gaussian kernel row-sum block: sequencer, registers and result stage.
//
// Stores up to MAX_SAMPLES samples of MAX_ATTRIB signed Q8.8 attributes plus a
// missing flag per sample. A write item (func 0) stores one attribute and the
// sample's missing flag and returns an all-zero item through S_FIN and the
// output register. A query item (func 1) walks every valid sample below
// sample_count, forms the squared distance to the queried sample, turns it into
// exp(-dist/(2 sigma^2)) by table and shift, accumulates, optionally scales by
// inv_norm and divides by the valid count for row_mean; both saturate to 32
// bits. All multiplications go through one registered 32x32 multiplier under a
// one-hot sequencer, and the mean comes from a one-bit-per-cycle divider. The
// per-attribute cost of a query is set by the single memory read port and the
// shared multiplier. Items are taken one at a time; a finished item waits in the
// output register while the next is accepted. After reset the missing flags are
// cleared one per cycle, so no item is taken until all MAX_SAMPLES flags are
// clear; configuration writes are taken throughout.
module gaussian_kernel_row_sum
    import gkrs_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_ATTRIB  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [9:0]  sample_index,
    input  logic [3:0]  attrib_index,
    input  logic signed [15:0] value,
    input  logic        missing,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] row_sum,
    output logic [31:0] row_mean,
    output logic        row_missing
);

    localparam int SW = $clog2(MAX_SAMPLES);
    localparam int AD = $clog2(MAX_SAMPLES * MAX_ATTRIB);
    localparam int AW = (MAX_ATTRIB > 1) ? $clog2(MAX_ATTRIB) : 1;

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_XFLAG = 20'h00002,
        S_CRD   = 20'h00004,
        S_CWR   = 20'h00008,
        S_YRD   = 20'h00010,
        S_YCHK  = 20'h00020,
        S_ARD   = 20'h00040,
        S_ASUB  = 20'h00080,
        S_AACC  = 20'h00100,
        S_KM1   = 20'h00200,
        S_KM2   = 20'h00400,
        S_KT    = 20'h00800,
        S_KU    = 20'h01000,
        S_KE    = 20'h02000,
        S_YNEXT = 20'h04000,
        S_NORM  = 20'h08000,
        S_NWAIT = 20'h10000,
        S_DIV   = 20'h20000,
        S_DWAIT = 20'h40000,
        S_FIN   = 20'h80000
    } state_t;

    // configuration
    logic [CNT_W-1:0] samp_cnt_reg;
    logic [NA_W-1:0]  attr_cnt_reg;
    logic [31:0]      inv_sig_reg;
    logic [31:0]      inv_norm_reg;
    logic             normed_reg;

    // sequencer
    state_t           state_reg, state_next;
    logic [9:0]       x_reg, x_next;
    logic [CNT_W-1:0] y_reg, y_next;
    logic [NA_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0] valid_reg, valid_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [63:0]      p1_reg, p1_next;
    logic [4:0]       ti_reg, ti_next;
    logic [4:0]       sh_reg, sh_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [FSUM_W-1:0] fsum_reg, fsum_next;
    logic [31:0]      res_sum_reg, res_sum_next;
    logic [31:0]      res_mean_reg, res_mean_next;
    logic             res_miss_reg, res_miss_next;
    logic [15:0]      xvec_reg [MAX_ATTRIB];

    // result stage
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_sum_reg, out_mean_reg;
    logic             out_miss_reg;

    // shared units
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      prod;
    logic             div_start;
    div_stat_t        div_stat;
    logic [DIV_W-1:0] quotient;

    // store
    st_ctrl_t         st_ctrl;
    logic [AD-1:0]    samp_addr;
    logic [15:0]      samp_rdata;
    logic [SW-1:0]    flag_addr;
    logic             flag_rdata;
    logic             clear_busy;

    // helpers
    logic [CNT_W-1:0] cnt_eff;
    logic [NA_W-1:0]  na_eff;
    logic             accept;
    logic             wr_ok;
    logic [16:0]      dd;
    logic [15:0]      dmag;
    logic [69:0]      tfull;
    logic [53:0]      tval;
    logic [25:0]      uval;
    logic [16:0]      tdiff;
    logic [16:0]      eval;

    assign cnt_eff = (32'(samp_cnt_reg) > MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES) : samp_cnt_reg;
    assign na_eff  = (32'(attr_cnt_reg) > MAX_ATTRIB) ? NA_W'(MAX_ATTRIB) : attr_cnt_reg;

    assign in_stall = !((state_reg == S_IDLE) && !clear_busy);
    assign accept   = in_valid && !in_stall;
    assign wr_ok    = (32'(sample_index) < MAX_SAMPLES) && (32'(attrib_index) < MAX_ATTRIB);

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samp_cnt_reg <= CNT_W'(1);
            attr_cnt_reg <= NA_W'(1);
            inv_sig_reg  <= ONE_Q16;
            inv_norm_reg <= ONE_Q16;
            normed_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_COUNT: samp_cnt_reg <= cfg_data[CNT_W-1:0];
                CFG_ATTRIB_COUNT: attr_cnt_reg <= cfg_data[NA_W-1:0];
                CFG_INV_TWO_SIG:  inv_sig_reg  <= cfg_data;
                CFG_INV_NORM:     inv_norm_reg <= cfg_data;
                CFG_NORMED:       normed_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // store addressing: writes and the query-x flag read come straight from the item
    always_comb
    begin
        st_ctrl.samp_we   = accept && (func == FUNC_WRITE) && wr_ok;
        st_ctrl.flag_we   = st_ctrl.samp_we;
        st_ctrl.flag_wval = missing;
        if (state_reg == S_IDLE)
        begin
            samp_addr = AD'(AD'(sample_index) * AD'(MAX_ATTRIB) + AD'(attrib_index));
            flag_addr = SW'(sample_index);
        end
        else if (state_reg == S_CRD)
        begin
            samp_addr = AD'(AD'(x_reg) * AD'(MAX_ATTRIB) + AD'(k_reg));
            flag_addr = SW'(y_reg);
        end
        else
        begin
            samp_addr = AD'(AD'(y_reg) * AD'(MAX_ATTRIB) + AD'(k_reg));
            flag_addr = SW'(y_reg);
        end
    end

    // datapath pieces feeding the multiplier
    assign dd    = {xvec_reg[AW'(k_reg)][15], xvec_reg[AW'(k_reg)]}
                 - {samp_rdata[15], samp_rdata};
    assign dmag  = dd[16] ? 16'(-dd) : dd[15:0];
    assign tfull = 70'(p1_reg) + (70'(prod[DIST_W-1:0]) << 32);
    assign tval  = tfull[69:16];
    assign uval  = prod[41:16];
    assign tdiff = EXP2_TAB[uval[15:11]] - EXP2_TAB[6'(uval[15:11]) + 6'd1];
    assign eval  = EXP2_TAB[ti_reg] - 17'(prod[21:11]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_ASUB:
            begin
                mul_a = 32'(dmag);
                mul_b = 32'(dmag);
            end
            S_KM1:
            begin
                mul_a = dist_reg[31:0];
                mul_b = inv_sig_reg;
            end
            S_KM2:
            begin
                mul_a = 32'(dist_reg[DIST_W-1:32]);
                mul_b = inv_sig_reg;
            end
            S_KT:
            begin
                mul_a = 32'(tval[24:0]);
                mul_b = LOG2E_Q16;
            end
            S_KU:
            begin
                mul_a = 32'(tdiff);
                mul_b = 32'(uval[10:0]);
            end
            S_NORM:
            begin
                mul_a = 32'(sum_reg);
                mul_b = inv_norm_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        k_next         = k_reg;
        valid_next     = valid_reg;
        dist_next      = dist_reg;
        p1_next        = p1_reg;
        ti_next        = ti_reg;
        sh_next        = sh_reg;
        sum_next       = sum_reg;
        fsum_next      = fsum_reg;
        res_sum_next   = res_sum_reg;
        res_mean_next  = res_mean_reg;
        res_miss_next  = res_miss_reg;
        div_start      = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_sum_next  = '0;
                    res_mean_next = '0;
                    res_miss_next = 1'b0;
                    x_next        = sample_index;
                    if (func == FUNC_QUERY && 11'(sample_index) < cnt_eff)
                    begin
                        state_next = S_XFLAG;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_XFLAG:
            begin
                k_next     = '0;
                y_next     = '0;
                sum_next   = '0;
                valid_next = '0;
                if (flag_rdata)
                begin
                    res_miss_next = 1'b1;
                    state_next    = S_FIN;
                end
                else if (na_eff == '0)
                begin
                    state_next = S_YRD;
                end
                else
                begin
                    state_next = S_CRD;
                end
            end
            S_CRD:
            begin
                state_next = S_CWR;
            end
            S_CWR:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 == na_eff)
                begin
                    state_next = S_YRD;
                end
                else
                begin
                    state_next = S_CRD;
                end
            end
            S_YRD:
            begin
                state_next = S_YCHK;
            end
            S_YCHK:
            begin
                k_next    = '0;
                dist_next = '0;
                if (flag_rdata)
                begin
                    state_next = S_YNEXT;
                end
                else
                begin
                    valid_next = valid_reg + 1'b1;
                    if (y_reg == 11'(x_reg))
                    begin
                        sum_next   = sum_reg + SUM_W'(ONE_Q16);
                        state_next = S_YNEXT;
                    end
                    else if (na_eff == '0)
                    begin
                        state_next = S_KM1;
                    end
                    else
                    begin
                        state_next = S_ARD;
                    end
                end
            end
            S_ARD:
            begin
                state_next = S_ASUB;
            end
            S_ASUB:
            begin
                state_next = S_AACC;
            end
            S_AACC:
            begin
                dist_next = dist_reg + DIST_W'(prod[31:0]);
                k_next    = k_reg + 1'b1;
                if (k_reg + 1'b1 == na_eff)
                begin
                    state_next = S_KM1;
                end
                else
                begin
                    state_next = S_ARD;
                end
            end
            S_KM1:
            begin
                state_next = S_KM2;
            end
            S_KM2:
            begin
                p1_next    = prod;
                state_next = S_KT;
            end
            S_KT:
            begin
                // from 24.0 on the term is zero
                if (tval >= T_CUTOFF)
                begin
                    state_next = S_YNEXT;
                end
                else
                begin
                    state_next = S_KU;
                end
            end
            S_KU:
            begin
                ti_next = uval[15:11];
                sh_next = uval[20:16];
                if (uval[25:16] >= 10'd17)
                begin
                    state_next = S_YNEXT;
                end
                else
                begin
                    state_next = S_KE;
                end
            end
            S_KE:
            begin
                sum_next   = sum_reg + SUM_W'(eval >> sh_reg);
                state_next = S_YNEXT;
            end
            S_YNEXT:
            begin
                y_next = y_reg + 1'b1;
                if (y_reg + 1'b1 >= cnt_eff)
                begin
                    state_next = S_NORM;
                end
                else
                begin
                    state_next = S_YRD;
                end
            end
            S_NORM:
            begin
                if (normed_reg)
                begin
                    state_next = S_NWAIT;
                end
                else
                begin
                    fsum_next  = FSUM_W'(sum_reg);
                    state_next = S_DIV;
                end
            end
            S_NWAIT:
            begin
                fsum_next  = prod[63:16];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                res_sum_next = (|fsum_reg[FSUM_W-1:32]) ? 32'hFFFF_FFFF : fsum_reg[31:0];
                if (valid_reg == '0)
                begin
                    res_mean_next = '0;
                    state_next    = S_FIN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                if (div_stat.done)
                begin
                    res_mean_next = (|quotient[DIV_W-1:32]) ? 32'hFFFF_FFFF : quotient[31:0];
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        k_reg        <= k_next;
        valid_reg    <= valid_next;
        dist_reg     <= dist_next;
        p1_reg       <= p1_next;
        ti_reg       <= ti_next;
        sh_reg       <= sh_next;
        sum_reg      <= sum_next;
        fsum_reg     <= fsum_next;
        res_sum_reg  <= res_sum_next;
        res_mean_reg <= res_mean_next;
        res_miss_reg <= res_miss_next;
        if (state_reg == S_CWR)
        begin
            xvec_reg[AW'(k_reg)] <= samp_rdata;
        end
        if (state_reg == S_FIN && (!out_valid_reg || !out_stall))
        begin
            out_sum_reg  <= res_sum_reg;
            out_mean_reg <= res_mean_reg;
            out_miss_reg <= res_miss_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_sum     = out_sum_reg;
    assign row_mean    = out_mean_reg;
    assign row_missing = out_miss_reg;

    gkrs_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    gkrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (fsum_reg),
        .divisor  (valid_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    gkrs_store #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_ATTRIB  (MAX_ATTRIB)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (st_ctrl),
        .samp_addr  (samp_addr),
        .samp_wdata (value),
        .samp_rdata (samp_rdata),
        .flag_addr  (flag_addr),
        .flag_rdata (flag_rdata),
        .clear_busy (clear_busy)
    );

`ifndef NO_ASSERTIONS
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == S_DWAIT)
        else $error("divider busy outside its wait state");

    a_valid_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_YNEXT |-> valid_reg <= y_reg + 1'b1)
        else $error("valid count ran ahead of the sample walk");

    a_attr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_AACC |-> k_reg < na_eff)
        else $error("attribute counter beyond attribute count");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_missing |-> row_sum == '0 && row_mean == '0)
        else $error("missing sample with non-zero sums");
`endif

endmodule
